// File: sv/dlsu_pkg.sv
// shared constants, types and codes of the data memory load/store unit
// no dependencies; every other file but dlsu_lane_ram depends on this package

package dlsu_pkg;

   // memory geometry: four big-endian byte lanes, lane l holds addresses with addr % 4 == l
   localparam int MEM_BYTES = 1024;
   localparam int LANES     = 4;
   localparam int LANE_ROWS = (MEM_BYTES + LANES - 1) / LANES;
   localparam int ROW_W     = (LANE_ROWS > 1) ? $clog2(LANE_ROWS) : 1;

   localparam int KIND_W = 4;
   localparam int DATA_W = 32;

   // highest legal start address for each access size
   localparam logic [DATA_W-1:0] LIMIT_WORD = DATA_W'(MEM_BYTES - 4);
   localparam logic [DATA_W-1:0] LIMIT_HALF = DATA_W'(MEM_BYTES - 2);
   localparam logic [DATA_W-1:0] LIMIT_BYTE = DATA_W'(MEM_BYTES - 1);
   localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(LANE_ROWS - 1);

   typedef enum logic [KIND_W-1:0] {
      KIND_NONE = 4'd0,
      KIND_SW   = 4'd1,
      KIND_SH   = 4'd2,
      KIND_SB   = 4'd3,
      KIND_LW   = 4'd4,
      KIND_LH   = 4'd5,
      KIND_LHU  = 4'd6,
      KIND_LB   = 4'd7,
      KIND_LBU  = 4'd8
   } kind_type;

   typedef enum logic [1:0] {
      SIZE_BYTE = 2'd0,
      SIZE_HALF = 2'd1,
      SIZE_WORD = 2'd2
   } size_type;

   // decoded access, handed from the decoder to the top level
   typedef struct packed {
      logic                       active;
      logic                       is_load;
      logic                       is_store;
      logic                       sign_ext;
      size_type                   size;
      logic                       misaligned;
      logic                       overflow;
      logic [1:0]                 offset;
      logic [LANES-1:0]           lane_en;
      logic [LANES-1:0][ROW_W-1:0] lane_row;
      logic [LANES-1:0][7:0]      lane_byte;
   } access_type;

endpackage

// File: sv/dlsu_req_if.sv
// request channel of the load/store unit: valid/ready plus access fields
// depends on dlsu_pkg

interface dlsu_req_if;
   logic                                valid;
   logic                                ready;
   logic [dlsu_pkg::KIND_W-1:0]         kind;
   logic signed [dlsu_pkg::DATA_W-1:0]  address;
   logic signed [dlsu_pkg::DATA_W-1:0]  store_data;

   modport source (output valid, kind, address, store_data, input ready);
   modport sink   (input valid, kind, address, store_data, output ready);
endinterface

// File: sv/dlsu_rsp_if.sv
// response channel of the load/store unit: valid/ready plus result fields
// depends on dlsu_pkg

interface dlsu_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [dlsu_pkg::DATA_W-1:0]  load_data;
   logic                                misaligned;
   logic                                address_overflow;

   modport source (output valid, load_data, misaligned, address_overflow, input ready);
   modport sink   (input valid, load_data, misaligned, address_overflow, output ready);
endinterface

// File: sv/dlsu_lane_ram.sv
// generic single-port synchronous ram with registered read
// no package dependency

module dlsu_lane_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic [AW-1:0]    addr,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
   end

   // read data holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/dlsu_decode.sv
// access decoder: kind, range and alignment checks, per-lane rows and store bytes
// depends on dlsu_pkg

module dlsu_decode (
   input  logic [dlsu_pkg::KIND_W-1:0]        kind,
   input  logic signed [dlsu_pkg::DATA_W-1:0] address,
   input  logic signed [dlsu_pkg::DATA_W-1:0] store_data,
   output dlsu_pkg::access_type               access
);
   import dlsu_pkg::*;

   logic [DATA_W-1:0] addr_u;
   logic [DATA_W-1:0] sdata_u;
   logic [ROW_W-1:0]  base_row;
   logic [1:0]        k;
   logic [1:0]        j;

   assign addr_u   = $unsigned(address);
   assign sdata_u  = $unsigned(store_data);
   assign base_row = addr_u[ROW_W+1:2];

   always_comb begin
      access          = '0;
      access.size     = SIZE_BYTE;
      access.offset   = addr_u[1:0];
      k               = '0;
      j               = '0;

      case (kind)
         KIND_SW:  begin access.active = 1'b1; access.is_store = 1'b1; access.size = SIZE_WORD; end
         KIND_SH:  begin access.active = 1'b1; access.is_store = 1'b1; access.size = SIZE_HALF; end
         KIND_SB:  begin access.active = 1'b1; access.is_store = 1'b1; access.size = SIZE_BYTE; end
         KIND_LW:  begin access.active = 1'b1; access.is_load = 1'b1; access.size = SIZE_WORD; end
         KIND_LH:  begin
            access.active = 1'b1; access.is_load = 1'b1; access.size = SIZE_HALF;
            access.sign_ext = 1'b1;
         end
         KIND_LHU: begin access.active = 1'b1; access.is_load = 1'b1; access.size = SIZE_HALF; end
         KIND_LB:  begin
            access.active = 1'b1; access.is_load = 1'b1; access.size = SIZE_BYTE;
            access.sign_ext = 1'b1;
         end
         KIND_LBU: begin access.active = 1'b1; access.is_load = 1'b1; access.size = SIZE_BYTE; end
         default:  begin access.active = 1'b0; end
      endcase

      // alignment and range
      case (access.size)
         SIZE_WORD: begin
            access.misaligned = access.active && (addr_u[1:0] != 2'b00);
            access.overflow   = access.active && (addr_u[DATA_W-1] || addr_u > LIMIT_WORD);
         end
         SIZE_HALF: begin
            access.misaligned = access.active && addr_u[0];
            access.overflow   = access.active && (addr_u[DATA_W-1] || addr_u > LIMIT_HALF);
         end
         default: begin
            access.misaligned = 1'b0;
            access.overflow   = access.active && (addr_u[DATA_W-1] || addr_u > LIMIT_BYTE);
         end
      endcase

      // lane l carries access byte k = l - offset; lanes below the offset wrap to the next row
      for (int l = 0; l < LANES; l++) begin
         k = 2'(l) - addr_u[1:0];
         access.lane_row[l] = base_row + ROW_W'(2'(l) < addr_u[1:0]);
         case (access.size)
            SIZE_WORD: begin
               access.lane_en[l] = 1'b1;
               j = 2'd3 - k;
            end
            SIZE_HALF: begin
               access.lane_en[l] = (k < 2'd2);
               j = 2'd1 - k;
            end
            default: begin
               access.lane_en[l] = (k == 2'd0);
               j = 2'd0;
            end
         endcase
         access.lane_en[l]   = access.lane_en[l] && access.active;
         access.lane_byte[l] = sdata_u[8*j +: 8];
      end
   end

endmodule

// File: sv/dlsu_load_align.sv
// load aligner: gathers big-endian bytes from the lanes and extends to 32 bits
// depends on dlsu_pkg

module dlsu_load_align (
   input  logic [dlsu_pkg::LANES-1:0][7:0] lane_data,
   input  logic [1:0]                      offset,
   input  dlsu_pkg::size_type              size,
   input  logic                            sign_ext,
   output logic [dlsu_pkg::DATA_W-1:0]     value
);
   import dlsu_pkg::*;

   logic [7:0] b0, b1, b2, b3;

   // access byte k sits in lane (offset + k) mod 4
   assign b0 = lane_data[offset];
   assign b1 = lane_data[offset + 2'd1];
   assign b2 = lane_data[offset + 2'd2];
   assign b3 = lane_data[offset + 2'd3];

   always_comb begin
      case (size)
         SIZE_WORD: value = {b0, b1, b2, b3};
         SIZE_HALF: value = {{16{sign_ext & b0[7]}}, b0, b1};
         default:   value = {{24{sign_ext & b0[7]}}, b0};
      endcase
   end

endmodule

// File: sv/byte_data_memory_load_store_unit.sv
// top level of the data memory load/store unit: lane rams, decode, pipeline, clear pass
// depends on dlsu_pkg, dlsu_req_if, dlsu_rsp_if, dlsu_decode, dlsu_lane_ram, dlsu_load_align

// Big-endian, byte-addressed data memory of MEM_BYTES bytes, kept as four byte-lane rams of
// MEM_BYTES/4 rows (256 at the default size). Every access touches each lane at most once, so a
// word access at any address, aligned or not, reads or writes all of its bytes in the same cycle.
// Throughput is one request per clock while the response side is not stalled; a response passes
// through stage 1 (the registered ram read) and the response register after its request is
// accepted. Stores write the lanes at the accept edge, so a load right behind a store sees the
// new bytes without forwarding. Out-of-range accesses set address_overflow and leave memory
// untouched; misaligned word or half accesses set misaligned and still go ahead. After reset
// the unit zeroes all MEM_BYTES/4 rows of the rams one row per cycle, with ready held low.

module byte_data_memory_load_store_unit (
   input  logic        clock,
   input  logic        reset,
   dlsu_req_if.sink    req_chan,
   dlsu_rsp_if.source  rsp_chan
);
   import dlsu_pkg::*;

   // decoded request
   access_type access;

   // clear pass control
   logic             clr_active_ff, clr_active_in;
   logic [ROW_W-1:0] clr_row_ff, clr_row_in;

   // stage 1: waiting for ram read data
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_load_ff;
   logic [1:0]        s1_offset_ff;
   size_type          s1_size_ff;
   logic              s1_sign_ff;
   logic [DATA_W-1:0] s1_sdata_ff;
   logic              s1_mis_ff;
   logic              s1_ovf_ff;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff;
   logic              rsp_mis_ff;
   logic              rsp_ovf_ff;

   // handshake
   logic req_fire;
   logic s1_adv;
   logic go_load;
   logic go_store;

   // lane ram ports
   logic [LANES-1:0]            lane_we;
   logic [LANES-1:0]            lane_re;
   logic [LANES-1:0][ROW_W-1:0] lane_addr;
   logic [LANES-1:0][7:0]       lane_wdata;
   logic [LANES-1:0][7:0]       lane_rdata;
   logic [DATA_W-1:0]           loaded;
   logic [DATA_W-1:0]           s1_result;

   dlsu_decode u_decode (
      .kind       (req_chan.kind),
      .address    (req_chan.address),
      .store_data (req_chan.store_data),
      .access     (access)
   );

   // stage 1 moves on when the response register is empty or being drained
   assign s1_adv         = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !clr_active_ff && (!s1_valid_ff || s1_adv);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign go_load        = req_fire && access.is_load && !access.overflow;
   assign go_store       = req_fire && access.is_store && !access.overflow;

   // lane ram drive: clear pass owns the rams until it finishes
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         lane_addr[l]  = clr_active_ff ? clr_row_ff : access.lane_row[l];
         lane_we[l]    = clr_active_ff || (go_store && access.lane_en[l]);
         lane_wdata[l] = clr_active_ff ? 8'h00 : access.lane_byte[l];
         lane_re[l]    = go_load;
      end
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      dlsu_lane_ram #(
         .DEPTH (LANE_ROWS),
         .WIDTH (8),
         .AW    (ROW_W)
      ) u_lane_ram (
         .clock   (clock),
         .addr    (lane_addr[g]),
         .wr_en   (lane_we[g]),
         .wr_data (lane_wdata[g]),
         .rd_en   (lane_re[g]),
         .rd_data (lane_rdata[g])
      );
   end

   dlsu_load_align u_load_align (
      .lane_data (lane_rdata),
      .offset    (s1_offset_ff),
      .size      (s1_size_ff),
      .sign_ext  (s1_sign_ff),
      .value     (loaded)
   );

   // skipped loads and everything else pass store data through
   assign s1_result = s1_load_ff ? loaded : s1_sdata_ff;

   // clear pass sequencing
   always_comb begin
      clr_active_in = clr_active_ff;
      clr_row_in    = clr_row_ff;
      if (clr_active_ff) begin
         if (clr_row_ff == LAST_ROW) begin
            clr_active_in = 1'b0;
         end else begin
            clr_row_in = clr_row_ff + ROW_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_row_ff    <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_row_ff    <= clr_row_in;
      end
   end

   // valid bits of stage 1 and the response register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = s1_adv ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // stage 1 payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_load_ff   <= access.is_load && !access.overflow;
         s1_offset_ff <= access.offset;
         s1_size_ff   <= access.size;
         s1_sign_ff   <= access.sign_ext;
         s1_sdata_ff  <= $unsigned(req_chan.store_data);
         s1_mis_ff    <= access.misaligned;
         s1_ovf_ff    <= access.overflow;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (s1_adv && s1_valid_ff) begin
         rsp_data_ff <= s1_result;
         rsp_mis_ff  <= s1_mis_ff;
         rsp_ovf_ff  <= s1_ovf_ff;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.load_data        = $signed(rsp_data_ff);
   assign rsp_chan.misaligned       = rsp_mis_ff;
   assign rsp_chan.address_overflow = rsp_ovf_ff;

   // an accepted request always lands in stage 1
   a_fire_fills_s1 : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted request did not reach stage 1");

   // outside the clear pass, ram writes come only from an in-range store
   a_write_source : assert property (@(posedge clock) disable iff (reset)
      (!clr_active_ff && (lane_we != '0)) |-> go_store)
      else $error("lane write without an in-range store");

   // a store writes exactly as many lanes as it has bytes
   a_store_lanes : assert property (@(posedge clock) disable iff (reset)
      go_store |-> ($countones(lane_we) ==
         ((access.size == SIZE_WORD) ? 4 : (access.size == SIZE_HALF) ? 2 : 1)))
      else $error("store lane count does not match access size");

   // the clear pass ends only after the last row
   a_clear_done : assert property (@(posedge clock) disable iff (reset)
      $fell(clr_active_ff) |-> ($past(clr_row_ff) == LAST_ROW))
      else $error("clear pass ended early");

endmodule
